### src/fcd_pkg.sv
// Shared types and constants for the framed command decoder.
// Used by every module under src; depends on nothing else.
package fcd_pkg;

  // Request kinds carried in the opcode field
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Command codes carried in the code byte of a frame
  localparam logic [7:0] CMD_CLEAR_FAULT = 8'd0;
  localparam logic [7:0] CMD_INV_ON      = 8'd1;
  localparam logic [7:0] CMD_INV_OFF     = 8'd2;
  localparam logic [7:0] CMD_AB_ON       = 8'd3;
  localparam logic [7:0] CMD_AB_OFF      = 8'd4;
  localparam logic [7:0] CMD_SETPOINT    = 8'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS     = 2'd2;

  // Reset values
  localparam logic [7:0] PREAMBLE_FIRST_RST  = 8'h50;  // 'P'
  localparam logic [7:0] PREAMBLE_SECOND_RST = 8'h52;  // 'R'
  localparam logic [7:0] PULSE_TICKS_RST     = 8'd1;
  localparam logic [7:0] SETPOINT_RST        = 8'h3F;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       start_inverter;
    logic       start_ab;
    logic [7:0] current_setpoint;
    logic       clear_fault_active;
    logic       frame_done;
  } out_item_t;

endpackage

### src/framed_command_decoder_core.sv
// An accepted request passes the input register, then its result is registered.
// Throughput: one request per cycle; the input register frees as the result
// register loads, so the pair streams as long as the output side takes results.
// Reset (rst, synchronous): both stages empty, preamble hunt restarted, outputs
// on, setpoint 0x3F, pulse disarmed, registers back to 'P', 'R', one tick.
module framed_command_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fcd_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fcd_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [fcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import fcd_pkg::*;

  logic      stage_valid;
  in_item_t  stage_item;
  out_item_t result;
  logic      advance;

  // Move the held request on when the result register has room
  assign advance = stage_valid && (!out_valid || out_ready);

  fcd_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  fcd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (stage_item),
    .result    (result)
  );

  fcd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### src/fcd_in_stage.sv
// Input register stage of the framed command decoder.
// Depends on fcd_pkg for the request type.
module fcd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcd_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              stage_valid,
  output fcd_pkg::in_item_t stage_item
);
  import fcd_pkg::*;

  // Take a new request whenever the held one moves on or none is held
  assign in_ready = !stage_valid || advance;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

### src/fcd_engine.sv
// Frame decoder, command state and fault-clear pulse timer.
// Holds the configuration registers; depends on fcd_pkg.
module fcd_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          advance,
  input  fcd_pkg::in_item_t             item,
  output fcd_pkg::out_item_t            result
);
  import fcd_pkg::*;

  logic [7:0] preamble_first;
  logic [7:0] preamble_second;
  logic [7:0] pulse_ticks;

  logic       in_data_phase, in_data_phase_next;
  logic       byte_index, byte_index_next;
  logic [7:0] held_code, held_code_next;
  logic       inverter_on, inverter_on_next;
  logic       ab_on, ab_on_next;
  logic [7:0] setpoint_level, setpoint_level_next;
  logic       pulse_armed, pulse_armed_next;
  logic [7:0] pulse_remaining, pulse_remaining_next;
  logic       line_active, line_active_next;
  logic       done;

  logic [7:0] pulse_len;
  logic [7:0] want;
  logic [7:0] remaining_dec;

  // Configuration writes; unused index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_first  <= PREAMBLE_FIRST_RST;
      preamble_second <= PREAMBLE_SECOND_RST;
      pulse_ticks     <= PULSE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PREAMBLE_FIRST:  preamble_first  <= cfg_data;
        CFG_PREAMBLE_SECOND: preamble_second <= cfg_data;
        CFG_PULSE_TICKS:     pulse_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero pulse length counts as one tick
  assign pulse_len     = (pulse_ticks == 8'd0) ? 8'd1 : pulse_ticks;
  assign want          = byte_index ? preamble_second : preamble_first;
  assign remaining_dec = pulse_remaining - 8'd1;

  // Next state for one request
  always_comb begin
    in_data_phase_next   = in_data_phase;
    byte_index_next      = byte_index;
    held_code_next       = held_code;
    inverter_on_next     = inverter_on;
    ab_on_next           = ab_on;
    setpoint_level_next  = setpoint_level;
    pulse_armed_next     = pulse_armed;
    pulse_remaining_next = pulse_remaining;
    line_active_next     = line_active;
    done                 = 1'b0;

    if (item.opcode == OP_BYTE) begin
      if (!in_data_phase) begin
        // Preamble hunt: a mismatch restarts at the first byte
        if (item.rx_byte == want) begin
          if (byte_index) begin
            byte_index_next    = 1'b0;
            in_data_phase_next = 1'b1;
          end else begin
            byte_index_next = 1'b1;
          end
        end else begin
          byte_index_next = 1'b0;
        end
      end else if (!byte_index) begin
        held_code_next  = item.rx_byte;
        byte_index_next = 1'b1;
      end else begin
        // Value byte: apply the held command and close the frame
        byte_index_next    = 1'b0;
        in_data_phase_next = 1'b0;
        done               = 1'b1;
        case (held_code)
          CMD_CLEAR_FAULT: begin
            if (!pulse_armed) begin
              pulse_armed_next     = 1'b1;
              pulse_remaining_next = pulse_len;
            end
          end
          CMD_INV_ON:   inverter_on_next    = 1'b1;
          CMD_INV_OFF:  inverter_on_next    = 1'b0;
          CMD_AB_ON:    ab_on_next          = 1'b1;
          CMD_AB_OFF:   ab_on_next          = 1'b0;
          CMD_SETPOINT: setpoint_level_next = item.rx_byte;
          default: ;
        endcase
      end
    end else begin
      // Tick: drive the line while armed, release otherwise
      if (!pulse_armed) begin
        line_active_next = 1'b0;
      end else begin
        line_active_next     = 1'b1;
        pulse_remaining_next = remaining_dec;
        if (remaining_dec == 8'd0) begin
          pulse_armed_next     = 1'b0;
          pulse_remaining_next = pulse_len;
        end
      end
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_data_phase   <= 1'b0;
      byte_index      <= 1'b0;
      inverter_on     <= 1'b1;
      ab_on           <= 1'b1;
      setpoint_level  <= SETPOINT_RST;
      pulse_armed     <= 1'b0;
      pulse_remaining <= PULSE_TICKS_RST;
      line_active     <= 1'b0;
    end else if (advance) begin
      in_data_phase   <= in_data_phase_next;
      byte_index      <= byte_index_next;
      inverter_on     <= inverter_on_next;
      ab_on           <= ab_on_next;
      setpoint_level  <= setpoint_level_next;
      pulse_armed     <= pulse_armed_next;
      pulse_remaining <= pulse_remaining_next;
      line_active     <= line_active_next;
    end
  end

  // Hold the code byte until the value byte arrives
  always_ff @(posedge clk) begin
    if (advance) begin
      held_code <= held_code_next;
    end
  end

  // Result reflects the state after this request
  always_comb begin
    result.start_inverter     = inverter_on_next;
    result.start_ab           = ab_on_next;
    result.current_setpoint   = setpoint_level_next;
    result.clear_fault_active = line_active_next;
    result.frame_done         = done;
  end

endmodule

### src/fcd_out_stage.sv
// Result register stage of the framed command decoder.
// Depends on fcd_pkg for the result type.
module fcd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  fcd_pkg::out_item_t result,
  output logic               out_valid,
  input  logic               out_ready,
  output fcd_pkg::out_item_t out_item
);
  import fcd_pkg::*;

  // Occupancy: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

### src/fcd_checker.sv
// Port-level checks for the framed command decoder, bound to the top level.
// Depends on fcd_pkg for the result type.
module fcd_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               out_valid,
  input  logic               out_ready,
  input  fcd_pkg::out_item_t out_item
);
  import fcd_pkg::*;

  logic      have_prev;
  out_item_t prev;

  // Remember the last result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev <= out_item;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // Command outputs change only on a completed frame
  a_cmd_only_on_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && have_prev && !out_item.frame_done |->
      out_item.start_inverter == prev.start_inverter &&
      out_item.start_ab == prev.start_ab &&
      out_item.current_setpoint == prev.current_setpoint)
    else $error("command output changed without a frame");

  // The fault-clear line only moves on ticks, never on a frame's last byte
  a_line_not_on_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && have_prev && out_item.frame_done |->
      out_item.clear_fault_active == prev.clear_fault_active)
    else $error("fault-clear line changed on a received byte");

endmodule

bind framed_command_decoder_core fcd_checker u_fcd_checker (.*);

### test/framed_command_decoder_core_test.sv
// Self-checking testbench for framed_command_decoder_core: random and directed
// byte/tick requests against a built-in decoder predictor. Needs fcd_pkg.
`timescale 1ns / 100ps

module framed_command_decoder_core_test;
  import fcd_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_PAD   = 8;     // extra wait after the last result arrives
  localparam int RANDOM_REQS = 110;   // random requests per segment
  localparam int MAX_LOGGED  = 40;

  // Index past the last register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  framed_command_decoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Register copies and decoder state of the predictor
  logic [7:0] pre_first;
  logic [7:0] pre_second;
  logic [7:0] pulse_ticks_cfg;
  logic       in_frame;
  logic       second_half;
  logic [7:0] code_byte;
  logic       inverter_on;
  logic       ab_on;
  logic [7:0] setpoint;
  logic       pulse_armed;
  logic [7:0] pulse_left;
  logic       fault_line;

  in_item_t  pending_requests[$];
  out_item_t expected_status[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int reqs_total     = 0;
  int results_seen   = 0;
  int ticks_sent     = 0;
  int frames_decoded = 0;
  int settings_run   = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;
  bit req_taken      = 1'b0;

  out_item_t  want_status;
  logic [7:0] known_codes[6] = '{CMD_CLEAR_FAULT, CMD_INV_ON, CMD_INV_OFF,
                                 CMD_AB_ON, CMD_AB_OFF, CMD_SETPOINT};

  function automatic logic [7:0] active_pulse_len();
    return (pulse_ticks_cfg == 8'd0) ? 8'd1 : pulse_ticks_cfg;
  endfunction

  // Advance the decoder by one request and return the status it shows after
  function automatic out_item_t decode_request(in_item_t req);
    out_item_t status;
    logic      done;
    done = 1'b0;
    if (req.opcode == OP_TICK) begin
      if (pulse_armed) begin
        fault_line = 1'b1;
        pulse_left = pulse_left - 8'd1;
        if (pulse_left == 8'd0) begin
          pulse_armed = 1'b0;
          pulse_left  = active_pulse_len();
        end
      end else begin
        fault_line = 1'b0;
      end
    end else if (!in_frame) begin
      // Preamble hunt; a mismatching byte just restarts at the first byte
      if (req.rx_byte == (second_half ? pre_second : pre_first)) begin
        if (second_half) begin
          second_half = 1'b0;
          in_frame    = 1'b1;
        end else begin
          second_half = 1'b1;
        end
      end else begin
        second_half = 1'b0;
      end
    end else if (!second_half) begin
      code_byte   = req.rx_byte;
      second_half = 1'b1;
    end else begin
      case (code_byte)
        CMD_CLEAR_FAULT: begin
          if (!pulse_armed) begin
            pulse_armed = 1'b1;
            pulse_left  = active_pulse_len();
          end
        end
        CMD_INV_ON:   inverter_on = 1'b1;
        CMD_INV_OFF:  inverter_on = 1'b0;
        CMD_AB_ON:    ab_on = 1'b1;
        CMD_AB_OFF:   ab_on = 1'b0;
        CMD_SETPOINT: setpoint = req.rx_byte;
        default: ;
      endcase
      second_half = 1'b0;
      in_frame    = 1'b0;
      done        = 1'b1;
      frames_decoded++;
    end
    status.start_inverter     = inverter_on;
    status.start_ab           = ab_on;
    status.current_setpoint   = setpoint;
    status.clear_fault_active = fault_line;
    status.frame_done         = done;
    return status;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_LOGGED)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Drive one register write and mirror it in the predictor
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_PREAMBLE_FIRST:  pre_first = value;
      CFG_PREAMBLE_SECOND: pre_second = value;
      CFG_PULSE_TICKS:     pulse_ticks_cfg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_byte(logic [7:0] value);
    in_item_t req;
    req.opcode  = OP_BYTE;
    req.rx_byte = value;
    pending_requests.push_back(req);
    reqs_total++;
  endtask

  task automatic add_tick();
    in_item_t req;
    req.opcode  = OP_TICK;
    req.rx_byte = 8'($urandom_range(255));
    pending_requests.push_back(req);
    reqs_total++;
    ticks_sent++;
  endtask

  task automatic add_frame(logic [7:0] code, logic [7:0] value);
    add_byte(pre_first);
    add_byte(pre_second);
    add_byte(code);
    add_byte(value);
  endtask

  // Mostly well-formed frames and tick bursts, with some noise and broken preambles
  task automatic add_random_traffic(int count);
    int         start;
    int         pick;
    int         sel;
    logic [7:0] code;
    start = reqs_total;
    while (reqs_total - start < count) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        repeat ($urandom_range(1, 4)) add_tick();
      end else if (pick < 80) begin
        sel = $urandom_range(7);
        if (sel < 6)
          code = known_codes[sel];
        else if (sel == 6)
          code = 8'($urandom_range(255));
        else
          code = CMD_CLEAR_FAULT;
        add_frame(code, 8'($urandom_range(255)));
      end else if (pick < 90) begin
        add_byte(8'($urandom_range(255)));
      end else begin
        add_byte(pre_first);
        add_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Drain, reprogram the registers, then switch the idle pattern
  task automatic start_segment(int send_pct, int stall_pct, logic [7:0] first,
                               logic [7:0] second, logic [7:0] plen);
    while (results_seen < reqs_total) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
    write_reg(CFG_PREAMBLE_FIRST, first);
    write_reg(CFG_PREAMBLE_SECOND, second);
    write_reg(CFG_PULSE_TICKS, plen);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    settings_run++;
  endtask

  // Request driver: hold until accepted, predict on acceptance, then idle or send
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken)
        expected_status.push_back(decode_request(in_item));
      if (in_valid && !req_taken) begin
        // hold the current request
      end else if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: note accepted requests and check each result against the oldest expectation
  always @(posedge clk) begin
    req_taken = !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want_status = expected_status.pop_front();
        if (out_item.start_inverter !== want_status.start_inverter)
          report_mismatch($sformatf("start_inverter got %0b want %0b",
                                    out_item.start_inverter, want_status.start_inverter));
        if (out_item.start_ab !== want_status.start_ab)
          report_mismatch($sformatf("start_ab got %0b want %0b",
                                    out_item.start_ab, want_status.start_ab));
        if (out_item.current_setpoint !== want_status.current_setpoint)
          report_mismatch($sformatf("current_setpoint got %0d want %0d",
                                    out_item.current_setpoint,
                                    want_status.current_setpoint));
        if (out_item.clear_fault_active !== want_status.clear_fault_active)
          report_mismatch($sformatf("clear_fault_active got %0b want %0b",
                                    out_item.clear_fault_active,
                                    want_status.clear_fault_active));
        if (out_item.frame_done !== want_status.frame_done)
          report_mismatch($sformatf("frame_done got %0b want %0b",
                                    out_item.frame_done, want_status.frame_done));
      end
    end
  end

  // Watchdog: stop when no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("framed_command_decoder_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    // Predictor starts from the reset state
    pre_first       = PREAMBLE_FIRST_RST;
    pre_second      = PREAMBLE_SECOND_RST;
    pulse_ticks_cfg = PULSE_TICKS_RST;
    in_frame        = 1'b0;
    second_half     = 1'b0;
    code_byte       = 8'd0;
    inverter_on     = 1'b1;
    ab_on           = 1'b1;
    setpoint        = SETPOINT_RST;
    pulse_armed     = 1'b0;
    pulse_left      = active_pulse_len();
    fault_line      = 1'b0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Default preamble and pulse length, plus a write to the spare index
    write_reg(CFG_SPARE, 8'hA5);
    start_segment(19, 54, PREAMBLE_FIRST_RST, PREAMBLE_SECOND_RST, PULSE_TICKS_RST);
    add_tick();
    // Broken preamble: the repeated first byte is not taken as a new start
    add_byte(pre_first);
    add_byte(pre_first);
    add_byte(pre_second);
    add_frame(CMD_INV_OFF, 8'h00);
    add_frame(CMD_AB_OFF, 8'hFF);
    add_frame(CMD_SETPOINT, 8'hFF);
    add_frame(CMD_CLEAR_FAULT, 8'h00);
    add_frame(8'hFF, 8'h00);
    add_tick();
    add_tick();
    add_random_traffic(RANDOM_REQS);
    // Leave a pulse armed so the next pulse length write lands mid-pulse
    add_frame(CMD_CLEAR_FAULT, 8'($urandom_range(255)));

    // Extreme preamble bytes; a zero pulse length acts as one tick
    start_segment(54, 19, 8'hFF, 8'h00, 8'h00);
    add_random_traffic(RANDOM_REQS);
    add_frame(CMD_CLEAR_FAULT, 8'($urandom_range(255)));

    // Swapped extremes and the longest pulse, no idling
    start_segment(0, 0, 8'h00, 8'hFF, 8'hFF);
    add_random_traffic(RANDOM_REQS);
    add_frame(CMD_CLEAR_FAULT, 8'($urandom_range(255)));

    // Identical preamble bytes and a two-tick pulse, no idling
    start_segment(0, 0, 8'h41, 8'h41, 8'd2);
    add_random_traffic(RANDOM_REQS);

    while (results_seen < reqs_total) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
    if (expected_status.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_status.size()));

    $display("ran %0d requests (%0d ticks, %0d completed frames) over %0d register settings",
             reqs_total, ticks_sent, frames_decoded, settings_run);
    $display("covered extreme preamble bytes and pulse lengths 0, 1, 2 and 255; %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("framed_command_decoder_core_test OK");
    else
      $display("framed_command_decoder_core_test NOT OK");
    $finish;
  end

endmodule
